>>> hw/rtl/http_chunked_body_decoder_macros.svh
// ============================================================================
// HTTP chunked body decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication
`define CHD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// Next-cycle implication
`define CHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

>>> hw/rtl/chd_pkg.sv
// ============================================================================
// chd_pkg
// Shared constants, types and the hex digit decoder of the chunked decoder.
// ============================================================================
package chd_pkg;

    // Width of chunk size and payload byte counters
    localparam int SIZE_BITS = 32;

    // Character codes
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X_LO = 8'h78;
    localparam logic [7:0] CHAR_X_UP = 8'h58;

    // Line-end bytes skipped after each chunk's payload
    localparam logic [1:0] CRLF_SKIP = 2'd2;

    // Size-line parser controls from the core
    typedef struct packed {
        logic parse;   // feed the byte to the hex parser
        logic clear;   // line ended: restart parser
    } size_ctl_t;

    // One step's result
    typedef struct packed {
        logic       emit;
        logic       eob;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic       vld;
        logic [3:0] val;
    } hex_digit_t;

    // Hex digit decode: 0-9, a-f, A-F
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] t;
        d = '{vld: 1'b0, val: 4'd0};
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            d = '{vld: 1'b1, val: t[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            d = '{vld: 1'b1, val: t[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            d = '{vld: 1'b1, val: t[3:0]};
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/http_chunked_body_decoder.sv
// ============================================================================
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer body decoder, one byte per request.
// ============================================================================
// Takes one body byte per accepted request and returns the payload bytes of
// each chunk, plus one end-of-body result for the zero-size chunk; all later
// bytes are dropped. Throughput is one byte per clock while a full result
// register is not stalled: the whole per-byte state update is combinational
// between the input register and the result register, so each byte is held
// in the input register and its result in the result register. The input
// register is held only while a byte that yields a result waits on a full,
// stalled result register. No clearing pass after reset.
// ============================================================================
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       end_of_body
);
    import chd_pkg::*;

    logic       stage_vld_reg, stage_vld_next;
    logic [7:0] stage_byte_reg;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] out_byte_reg;
    logic       out_eob_reg;
    result_t    res;
    logic       adv;
    logic       in_acc;
    logic       finished;

    chd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_byte  (stage_byte_reg),
        .res      (res),
        .finished (finished)
    );

    // Stage advances unless its result has nowhere to go
    assign adv      = stage_vld_reg && (!res.emit || !out_vld_reg || out_ready);
    assign in_ready = !stage_vld_reg || adv;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (in_acc)
            stage_vld_next = 1'b1;
        else if (adv)
            stage_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (adv && res.emit)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_vld_reg <= 1'b0;
        else
            stage_vld_reg <= stage_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            stage_byte_reg <= in_byte;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && res.emit)
        begin
            out_byte_reg <= res.data;
            out_eob_reg  <= res.eob;
        end
    end

    assign out_valid    = out_vld_reg;
    assign payload_byte = out_byte_reg;
    assign end_of_body  = out_eob_reg;

    // Checks
    `CHD_ASSERT_NOW(a_eob_zero_byte, out_vld_reg && out_eob_reg, out_byte_reg == 8'd0)
    `CHD_ASSERT_NEXT(a_eob_last, out_vld_reg && out_ready && out_eob_reg, !out_vld_reg)
    `CHD_ASSERT_NEXT(a_stage_hold, stage_vld_reg && !adv, stage_vld_reg && $stable(stage_byte_reg))
    `CHD_ASSERT_NOW(a_finished_silent, finished, !res.emit)

endmodule

>>> hw/rtl/chd_size_parse.sv
// ============================================================================
// chd_size_parse
// Chunk size line parser: blanks, optional 0x prefix, saturating hex value.
// ============================================================================
module chd_size_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chd_pkg::size_ctl_t            ctl,
    input  logic [7:0]                    in_byte,
    output logic [chd_pkg::SIZE_BITS-1:0] size_accum
);
    import chd_pkg::*;

    typedef enum logic [1:0] {
        HX_BLANK,
        HX_ZERO,
        HX_DIGITS,
        HX_STOP
    } hex_phase_t;

    hex_phase_t           hex_phase_reg, hex_phase_next;
    logic [SIZE_BITS-1:0] accum_reg, accum_next;
    logic [SIZE_BITS-1:0] accum_add;
    hex_digit_t           dig;
    logic                 blank;

    // Digit decode and saturating shift-in
    always_comb
    begin
        dig   = hex_decode(in_byte);
        blank = (in_byte == CHAR_SP) || (in_byte == CHAR_TAB) ||
                (in_byte == CHAR_VT) || (in_byte == CHAR_FF);
        if (|accum_reg[SIZE_BITS-1 -: 4])
            accum_add = '1;
        else
            accum_add = {accum_reg[SIZE_BITS-5:0], dig.val};
    end

    // Parser phase
    always_comb
    begin
        hex_phase_next = hex_phase_reg;
        accum_next     = accum_reg;
        if (ctl.clear)
        begin
            hex_phase_next = HX_BLANK;
            accum_next     = '0;
        end
        else if (ctl.parse)
        begin
            case (hex_phase_reg)
                HX_BLANK:
                begin
                    if (!blank)
                    begin
                        if (in_byte == CHAR_ZERO)
                            hex_phase_next = HX_ZERO;
                        else if (dig.vld)
                        begin
                            accum_next     = accum_add;
                            hex_phase_next = HX_DIGITS;
                        end
                        else
                            hex_phase_next = HX_STOP;
                    end
                end
                HX_ZERO:
                begin
                    if (in_byte == CHAR_X_LO || in_byte == CHAR_X_UP)
                        hex_phase_next = HX_DIGITS;
                    else if (dig.vld)
                    begin
                        accum_next     = accum_add;
                        hex_phase_next = HX_DIGITS;
                    end
                    else
                        hex_phase_next = HX_STOP;
                end
                HX_DIGITS:
                begin
                    if (dig.vld)
                        accum_next = accum_add;
                    else
                        hex_phase_next = HX_STOP;
                end
                default:
                begin
                    hex_phase_next = hex_phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_phase_reg <= HX_BLANK;
            accum_reg     <= '0;
        end
        else
        begin
            hex_phase_reg <= hex_phase_next;
            accum_reg     <= accum_next;
        end
    end

    assign size_accum = accum_reg;

endmodule

>>> hw/rtl/chd_core.sv
// ============================================================================
// chd_core
// Per-byte decoder state: size line, payload count, CRLF skip, end of body.
// ============================================================================
module chd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [7:0]         in_byte,
    output chd_pkg::result_t   res,
    output logic               finished
);
    import chd_pkg::*;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_CRLF
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    logic [1:0]           crlf_left_reg, crlf_left_next;
    logic                 finished_reg, finished_next;
    logic [1:0]           crlf_dec;
    logic [SIZE_BITS-1:0] size_accum;
    size_ctl_t            size_ctl;
    logic                 is_crlf;

    chd_size_parse u_size (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (size_ctl),
        .in_byte    (in_byte),
        .size_accum (size_accum)
    );

    // Step logic
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        crlf_left_next = crlf_left_reg;
        finished_next  = finished_reg;
        res            = '{emit: 1'b0, eob: 1'b0, data: 8'd0};
        size_ctl       = '{parse: 1'b0, clear: 1'b0};
        is_crlf        = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
        crlf_dec       = (crlf_left_reg != 2'd0) ? crlf_left_reg - 2'd1 : crlf_left_reg;

        if (!finished_reg)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (remaining_reg == '0)
                        phase_next = PH_SIZE;
                    else
                    begin
                        res            = '{emit: 1'b1, eob: 1'b0, data: in_byte};
                        remaining_next = remaining_reg - SIZE_BITS'(1);
                        if (remaining_reg == SIZE_BITS'(1))
                        begin
                            phase_next     = PH_CRLF;
                            crlf_left_next = CRLF_SKIP;
                        end
                    end
                end
                PH_CRLF:
                begin
                    if (is_crlf)
                    begin
                        crlf_left_next = crlf_dec;
                        if (crlf_dec == 2'd0)
                            phase_next = PH_SIZE;
                    end
                end
                default:
                begin
                    // size line, also the spare phase code
                    phase_next = PH_SIZE;
                    if (in_byte == CHAR_LF)
                    begin
                        size_ctl.clear = adv;
                        if (size_accum == '0)
                        begin
                            finished_next = 1'b1;
                            res           = '{emit: 1'b1, eob: 1'b1, data: 8'd0};
                        end
                        else
                        begin
                            remaining_next = size_accum;
                            phase_next     = PH_DATA;
                        end
                    end
                    else if (in_byte != CHAR_CR)
                        size_ctl.parse = adv;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            remaining_reg <= '0;
            crlf_left_reg <= 2'd0;
            finished_reg  <= 1'b0;
        end
        else if (adv)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            crlf_left_reg <= crlf_left_next;
            finished_reg  <= finished_next;
        end
    end

    assign finished = finished_reg;

endmodule

>>> tb/sv/tb.sv
// ============================================================================
// tb: testbench for http_chunked_body_decoder
// Builds one long chunked body out of directed and random chunks and drives it
// byte by byte with random idle bursts on both sides. A scoreboard class tracks
// the chunk framing, predicts each payload byte and the end-of-body marker,
// and checks every result in order.
// ============================================================================

// Expected-output tracker: follows the chunk framing of the body and keeps the
// decoded bytes still owed by the design.
class chunk_body_model;

    typedef enum logic [1:0] {ST_SIZE_LINE, ST_PAYLOAD, ST_LINE_END, ST_SPARE} body_state_e;
    typedef enum logic [1:0] {NUM_BLANKS, NUM_LEAD_ZERO, NUM_DIGITS, NUM_STOPPED} size_parse_e;

    typedef struct packed {
        logic [7:0] payload;
        logic       end_flag;
    } decoded_t;

    body_state_e                    state;
    size_parse_e                    num_state;
    logic [chd_pkg::SIZE_BITS-1:0]  bytes_left;
    logic [chd_pkg::SIZE_BITS-1:0]  size_so_far;
    logic [1:0]                     eol_left;
    bit                             body_done;
    decoded_t                       expected_out[$];
    int                             mismatches;
    int                             results_seen;
    int                             ends_seen;

    function new();
        state        = ST_SIZE_LINE;
        num_state    = NUM_BLANKS;
        bytes_left   = '0;
        size_so_far  = '0;
        eol_left     = 2'd0;
        body_done    = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        ends_seen    = 0;
    endfunction

    // Hex digit value, -1 for anything else
    static function int digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // Shift in one digit, pinning at all ones once it would overflow
    function void take_digit(int d);
        logic [chd_pkg::SIZE_BITS-1:0] size_max;
        size_max = '1;
        if (size_so_far > (size_max >> 4))
            size_so_far = size_max;
        else
            size_so_far = {size_so_far[chd_pkg::SIZE_BITS-5:0], 4'(d)};
    endfunction

    function int pending();
        return expected_out.size();
    endfunction

    // One accepted request byte
    function void note_request(logic [7:0] c);
        int d;
        if (body_done)
            return;
        case (state)
            ST_PAYLOAD:
            begin
                if (bytes_left == 0)
                begin
                    state = ST_SIZE_LINE;
                end
                else
                begin
                    expected_out.push_back('{payload: c, end_flag: 1'b0});
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == 0)
                    begin
                        state    = ST_LINE_END;
                        eol_left = chd_pkg::CRLF_SKIP;
                    end
                end
            end
            ST_LINE_END:
            begin
                // only CR and LF count down; anything else is swallowed
                if (c == chd_pkg::CHAR_CR || c == chd_pkg::CHAR_LF)
                begin
                    if (eol_left != 0)
                        eol_left = eol_left - 1'b1;
                    if (eol_left == 0)
                        state = ST_SIZE_LINE;
                end
            end
            default:
            begin
                state = ST_SIZE_LINE;
                if (c == chd_pkg::CHAR_LF)
                begin
                    // line done: zero size ends the body
                    if (size_so_far == 0)
                    begin
                        body_done = 1'b1;
                        expected_out.push_back('{payload: 8'h00, end_flag: 1'b1});
                    end
                    else
                    begin
                        bytes_left = size_so_far;
                        state      = ST_PAYLOAD;
                    end
                    size_so_far = '0;
                    num_state   = NUM_BLANKS;
                end
                else if (c != chd_pkg::CHAR_CR)
                begin
                    d = digit_value(c);
                    case (num_state)
                        NUM_BLANKS:
                        begin
                            if (c == chd_pkg::CHAR_SP || c == chd_pkg::CHAR_TAB ||
                                c == chd_pkg::CHAR_VT || c == chd_pkg::CHAR_FF)
                                num_state = NUM_BLANKS;
                            else if (c == chd_pkg::CHAR_ZERO)
                                num_state = NUM_LEAD_ZERO;
                            else if (d >= 0)
                            begin
                                take_digit(d);
                                num_state = NUM_DIGITS;
                            end
                            else
                                num_state = NUM_STOPPED;
                        end
                        NUM_LEAD_ZERO:
                        begin
                            if (c == chd_pkg::CHAR_X_LO || c == chd_pkg::CHAR_X_UP)
                                num_state = NUM_DIGITS;
                            else if (d >= 0)
                            begin
                                take_digit(d);
                                num_state = NUM_DIGITS;
                            end
                            else
                                num_state = NUM_STOPPED;
                        end
                        NUM_DIGITS:
                        begin
                            if (d >= 0)
                                take_digit(d);
                            else
                                num_state = NUM_STOPPED;
                        end
                        default:
                        begin
                            // extension text: ignored up to LF
                        end
                    endcase
                end
            end
        endcase
    endfunction

    // One accepted result, compared with the oldest expected one
    function void check_result(logic [7:0] pb, logic eob);
        decoded_t want;
        if (expected_out.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 200)
                $display("%0t: unexpected result, expected none, got payload_byte=%h end_of_body=%b",
                         $time, pb, eob);
            return;
        end
        want = expected_out.pop_front();
        results_seen++;
        if (want.end_flag)
            ends_seen++;
        if (pb !== want.payload)
        begin
            mismatches++;
            if (mismatches <= 200)
                $display("%0t: payload_byte mismatch, expected %h, got %h",
                         $time, want.payload, pb);
        end
        if (eob !== want.end_flag)
        begin
            mismatches++;
            if (mismatches <= 200)
                $display("%0t: end_of_body mismatch, expected %b, got %b",
                         $time, want.end_flag, eob);
        end
    endfunction

endclass

module tb;

    import chd_pkg::*;

    localparam int ITEM_TARGET    = 1700;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] payload_byte;
    logic       end_of_body;

    chunk_body_model decoder_model;

    logic [7:0] body_stream[$];
    int         chunks_built;
    int         bytes_sent;
    int         idle_cycles;
    int         stall_left;
    bit         quiet;
    bit         hold_request;
    bit         end_with_zero;

    http_chunked_body_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .end_of_body  (end_of_body)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Body stream construction
    // ------------------------------------------------------------------
    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++)
            body_stream.push_back(s[k]);
    endfunction

    function automatic void push_line_end();
        body_stream.push_back(CHAR_CR);
        body_stream.push_back(CHAR_LF);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CHAR_SP;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    // Size line for a nonzero size, with random blanks, prefix, case,
    // stray CRs and extension text
    function automatic void add_size_line(logic [SIZE_BITS-1:0] n);
        int         nib;
        int         form;
        logic [3:0] d;
        logic [7:0] ch;
        nib = 1;
        for (int k = 1; k < SIZE_BITS / 4; k++)
            if (n[4*k +: 4] != 4'd0)
                nib = k + 1;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) body_stream.push_back(pick_blank());
        form = $urandom_range(0, 5);
        if (form == 0)
            push_text("0x");
        else if (form == 1)
            push_text("0X");
        else if (form == 2)
            repeat ($urandom_range(1, 2)) body_stream.push_back(CHAR_ZERO);
        for (int k = nib - 1; k >= 0; k--)
        begin
            if ($urandom_range(0, 15) == 0)
                body_stream.push_back(CHAR_CR);
            d = n[4*k +: 4];
            if (d < 10)
                ch = 8'h30 + 8'(d);
            else
                ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
            body_stream.push_back(ch);
        end
        // extension: opens on a non-hex byte, then anything but LF
        if ($urandom_range(0, 3) == 0)
        begin
            do
                ch = 8'($urandom_range(0, 255));
            while (decoder_model.digit_value(ch) >= 0 || ch == CHAR_CR || ch == CHAR_LF);
            body_stream.push_back(ch);
            repeat ($urandom_range(0, 6))
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == CHAR_LF);
                body_stream.push_back(ch);
            end
        end
        if ($urandom_range(0, 5) == 0)
            body_stream.push_back(CHAR_LF);
        else
            push_line_end();
    endfunction

    // One full chunk: size line, payload, trailing line end
    function automatic void add_chunk(logic [SIZE_BITS-1:0] n);
        logic [7:0] ch;
        add_size_line(n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                body_stream.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            else
                body_stream.push_back(8'($urandom_range(0, 255)));
        end
        // junk before the line end is swallowed
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                do
                    ch = 8'($urandom_range(0, 255));
                while (ch == CHAR_CR || ch == CHAR_LF);
                body_stream.push_back(ch);
            end
        end
        if ($urandom_range(0, 3) != 0)
        begin
            push_line_end();
        end
        else
        begin
            body_stream.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            body_stream.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end
        chunks_built++;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decoder_model.note_request(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Sender stops until every expected result is out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (decoder_model.pending() != 0);
    endtask

    // Receiver: random stall bursts plus one long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            decoder_model.check_result(payload_byte, end_of_body);
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int directed_len;
        int mid_point;
        int quiet_from;
        int n;
        int r;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        bytes_sent    = 0;
        chunks_built  = 0;
        decoder_model = new();

        // directed: blanks before a 0X prefix, zero payload byte
        push_text(" ");
        body_stream.push_back(CHAR_TAB);
        body_stream.push_back(CHAR_VT);
        body_stream.push_back(CHAR_FF);
        push_text("0X1");
        push_line_end();
        body_stream.push_back(8'h00);
        push_line_end();
        // lowercase prefix with extension, all-ones and LF payload, junk before LF CR
        push_text("0x2;e=v");
        push_line_end();
        body_stream.push_back(8'hFF);
        body_stream.push_back(CHAR_LF);
        push_text("q");
        body_stream.push_back(CHAR_LF);
        body_stream.push_back(CHAR_CR);
        // leading zero, CR inside the number, blank stops digits, bare LF
        push_text("0");
        body_stream.push_back(CHAR_CR);
        push_text("1 ");
        body_stream.push_back(CHAR_LF);
        body_stream.push_back(CHAR_CR);
        body_stream.push_back(CHAR_CR);
        body_stream.push_back(CHAR_CR);
        directed_len = body_stream.size();

        // random chunks, mostly short
        while (body_stream.size() < ITEM_TARGET)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
                n = $urandom_range(17, 64);
            else if (r == 1)
                n = $urandom_range(9, 16);
            else
                n = $urandom_range(1, 8);
            add_chunk(n);
        end

        // The body can close only once per reset, so each run picks one ending:
        // a zero-size chunk, or a size that saturates and never runs out.
        end_with_zero = $urandom_range(0, 1);
        if (end_with_zero)
        begin
            case ($urandom_range(0, 5))
                0: push_text("0");
                1:
                begin
                    body_stream.push_back(pick_blank());
                    push_text("0x;e=1");   // prefix with no digits
                end
                2: push_text("000");
                3: push_text("");
                4: push_text("0X");
                default: push_text("zz");
            endcase
            push_line_end();
            // everything after the terminator is dropped
            repeat ($urandom_range(4, 20)) body_stream.push_back(8'($urandom_range(0, 255)));
            push_text("5");
            push_line_end();
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: push_text("0xfffffffff");
                1: push_text("0x100000001");
                default: push_text("123456789ABCDEF0");
            endcase
            push_line_end();
            repeat (60) body_stream.push_back(8'($urandom_range(0, 255)));
        end

        mid_point  = body_stream.size() / 2;
        quiet_from = body_stream.size() - QUIET_TAIL;

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < body_stream.size(); i++)
        begin
            if (i == directed_len)
            begin
                wait_for_drain();
                hold_request = 1'b1;
            end
            else if (i == mid_point)
            begin
                wait_for_drain();
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            if (i >= quiet_from)
                quiet = 1'b1;
            send_byte(body_stream[i]);
        end
        in_valid <= 1'b0;

        while (decoder_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d body bytes in %0d random chunks plus directed lines; %0d results checked.",
                 bytes_sent, chunks_built, decoder_model.results_seen);
        if (end_with_zero)
            $display("Body closed by a zero-size chunk (%0d end marker seen), later bytes dropped.",
                     decoder_model.ends_seen);
        else
            $display("Body ended inside a chunk whose size saturated at the counter maximum.");
        if (decoder_model.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> http_chunked_body_decoder.f
+incdir+hw/rtl
hw/rtl/chd_pkg.sv
hw/rtl/chd_size_parse.sv
hw/rtl/chd_core.sv
hw/rtl/http_chunked_body_decoder.sv
tb/sv/tb.sv
